// ===== hw/rtl/mbaf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbaf_pkg
// Shared types, constants and helpers of the Modbus ASCII request framer.
// ----------------------------------------------------------------------------
package mbaf_pkg;

   localparam int BYTE_W        = 8;
   localparam int CHAR_W        = 7;
   localparam int PAYLOAD_BYTES = 6;
   localparam int FRAME_BYTES   = PAYLOAD_BYTES + 1;   // payload plus LRC
   localparam int SEL_W         = $clog2(FRAME_BYTES);
   localparam int FRAME_CHARS   = 17;
   localparam int IDX_W         = $clog2(FRAME_CHARS);

   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   // character positions inside one frame
   localparam logic [IDX_W-1:0] IDX_START = IDX_W'(0);
   localparam logic [IDX_W-1:0] IDX_CR    = IDX_W'(FRAME_CHARS - 2);
   localparam logic [IDX_W-1:0] IDX_LF    = IDX_W'(FRAME_CHARS - 1);

   localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 7'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 7'h0A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;

   // one queued frame: six payload bytes in send order, then the LRC
   typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] frame_bytes_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] ch;
      if (nib < 4'd10) begin
         ch = CHAR_ZERO + CHAR_W'(nib);
      end else begin
         ch = CHAR_A + CHAR_W'(nib - 4'd10);
      end
      return ch;
   endfunction

endpackage

// ===== hw/rtl/mbaf_if.sv =====
// ----------------------------------------------------------------------------
// mbaf_req_if / mbaf_rsp_if
// Valid/ready channels for requests in and frame characters out.
// ----------------------------------------------------------------------------
interface mbaf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  node_addr;
   logic [7:0]  function_code;
   logic [15:0] reg_address;
   logic [15:0] data_word;

   modport source (output valid, node_addr, function_code, reg_address, data_word,
                   input ready);
   modport sink   (input valid, node_addr, function_code, reg_address, data_word,
                   output ready);
endinterface

interface mbaf_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] character;
   logic       last;

   modport source (output valid, character, last, input ready);
   modport sink   (input valid, character, last, output ready);
endinterface

// ===== hw/rtl/mbaf_front.sv =====
// ----------------------------------------------------------------------------
// mbaf_front
// Accepts a request, splits it into frame bytes and appends the LRC.
// ----------------------------------------------------------------------------
module mbaf_front import mbaf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mbaf_req_if.sink             req_chan,
   output logic                 push_valid,
   input  logic                 push_ready,
   output frame_bytes_type      push_frame
);

   logic                                       front_valid_ff, front_valid_in;
   logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0]       front_bytes_ff, front_bytes_in;
   logic [BYTE_W-1:0]                          sum;
   logic                                       accept;

   assign req_chan.ready = !front_valid_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push_valid     = front_valid_ff;

   always_comb begin
      sum = '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         sum = sum + front_bytes_ff[i];
      end
      push_frame = {BYTE_W'(~sum + 8'd1), front_bytes_ff};
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      front_bytes_in = front_bytes_ff;
      if (accept) begin
         front_valid_in    = 1'b1;
         front_bytes_in[0] = req_chan.node_addr;
         front_bytes_in[1] = req_chan.function_code;
         front_bytes_in[2] = req_chan.reg_address[15:8];
         front_bytes_in[3] = req_chan.reg_address[7:0];
         front_bytes_in[4] = req_chan.data_word[15:8];
         front_bytes_in[5] = req_chan.data_word[7:0];
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_bytes_ff <= front_bytes_in;
   end

endmodule

// ===== hw/rtl/mbaf_queue.sv =====
// ----------------------------------------------------------------------------
// mbaf_queue
// Short frame queue between the front and back parts.
// ----------------------------------------------------------------------------
module mbaf_queue import mbaf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  frame_bytes_type  push_frame,
   output logic             pop_valid,
   input  logic             pop_ready,
   output frame_bytes_type  pop_frame
);

   frame_bytes_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                      do_push, do_pop;

   assign push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_frame  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ===== hw/rtl/mbaf_back.sv =====
// ----------------------------------------------------------------------------
// mbaf_back
// Walks one queued frame, one ASCII character per cycle unless output stalls.
// ----------------------------------------------------------------------------
module mbaf_back import mbaf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  frame_bytes_type  pop_frame,
   mbaf_rsp_if.source       rsp_chan
);

   logic                  cur_valid_ff, cur_valid_in;
   frame_bytes_type       cur_frame_ff, cur_frame_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]     out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;

   logic                  out_free, emit, frame_done;
   logic [IDX_W-1:0]      idx_m1;
   logic [SEL_W-1:0]      byte_sel;
   logic [BYTE_W-1:0]     cur_byte;
   logic [CHAR_W-1:0]     next_char;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign emit       = cur_valid_ff && out_free;
   assign frame_done = emit && (idx_ff == IDX_LF);
   assign pop_ready  = !cur_valid_ff || frame_done;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.character = out_char_ff;
   assign rsp_chan.last      = out_last_ff;

   // hex digits start at position one, two per byte, high nibble first
   assign idx_m1   = idx_ff - IDX_W'(1);
   assign byte_sel = idx_m1[SEL_W:1];

   always_comb begin
      cur_byte = '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (byte_sel == SEL_W'(i)) begin
            cur_byte = cur_frame_ff[i];
         end
      end
   end

   always_comb begin
      case (idx_ff)
         IDX_START: next_char = CHAR_COLON;
         IDX_CR:    next_char = CHAR_CR;
         IDX_LF:    next_char = CHAR_LF;
         default:   next_char = idx_m1[0] ? hex_char(cur_byte[3:0])
                                          : hex_char(cur_byte[7:4]);
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_frame_in = cur_frame_ff;
      idx_in       = idx_ff;
      if (pop_valid && pop_ready) begin
         cur_valid_in = 1'b1;
         cur_frame_in = pop_frame;
         idx_in       = IDX_START;
      end else if (frame_done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = next_char;
         out_last_in  = idx_ff == IDX_LF;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= IDX_START;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      cur_frame_ff <= cur_frame_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

endmodule

// ===== hw/rtl/modbus_ascii_request_framer.sv =====
// Path: a frame's first character (the colon) passes the front register, the
//   queue, the back frame register and its output register; LF comes last.
// Throughput: one character per cycle while the output is not stalled, set by the
//   single character output of the back part.
// Reset: synchronous; clears the front stage, queue and back part valid state.
//   No clearing pass, so a request may be taken in the first cycle after reset.
// ----------------------------------------------------------------------------
// modbus_ascii_request_framer
// Turns each Modbus request into a 17-character ASCII frame with LRC.
// ----------------------------------------------------------------------------
module modbus_ascii_request_framer import mbaf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   mbaf_req_if.sink     req_chan,
   mbaf_rsp_if.source   rsp_chan
);

   // front -> queue
   logic             push_valid;
   logic             push_ready;
   frame_bytes_type  push_frame;

   // queue -> back
   logic             pop_valid;
   logic             pop_ready;
   frame_bytes_type  pop_frame;

   // Front: register the request bytes and append the LRC on the way out,
   // so a new request can enter as soon as the previous one moves on.
   mbaf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame)
   );

   // Queue: hold up to two complete frames, so the front keeps taking
   // requests while the back is still sending a frame.
   mbaf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame)
   );

   // Back: step through colon, twelve payload digits, two LRC digits, CR, LF.
   // The next frame is loaded in the same cycle the line feed goes out,
   // so frames follow with no gap.
   mbaf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame),
      .rsp_chan   (rsp_chan)
   );

endmodule
